FILE: hw/rtl/rnad_pkg.sv
// Shared types and constants for the radix number to ASCII digit converter.
// No dependencies; used by rnad_ctrl, rnad_dpath and the top level.
`default_nettype none

package rnad_pkg;

   localparam int NUMBER_W         = 32;
   localparam int RADIX_W          = 8;
   localparam int CHAR_W           = 8;
   localparam int REQ_TDATA_W      = NUMBER_W + RADIX_W;
   localparam int RSP_TDATA_W      = CHAR_W;
   localparam int DEFAULT_NUM_BITS = 32;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_UPPER = 8'h41;
   localparam logic [CHAR_W-1:0] DIGIT_LIMIT = 8'd10;
   localparam logic [RADIX_W-1:0] MIN_RADIX  = 8'd2;

   // controller -> datapath
   typedef struct packed {
      logic load;      // take a request word
      logic step;      // one restoring-divide bit
      logic pop;       // move top digit to the output register
      logic emit_err;  // load the rejected-radix word
   } rnad_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic radix_bad;   // incoming radix below two
      logic last_bit;    // current step finishes one digit
      logic quot_zero;   // quotient after this step is zero
      logic last_digit;  // one digit left on the stack
      logic slot_free;   // output register can take a word
   } rnad_sts_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [CHAR_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d >= DIGIT_LIMIT) begin
         c = d + (ASCII_UPPER - DIGIT_LIMIT);
      end else begin
         c = d + ASCII_ZERO;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rnad_ctrl.sv
// Sequencer for the radix converter: accept, divide per digit, emit, or reject a bad radix.
// Depends on rnad_pkg for the command and status structs.
`default_nettype none

module rnad_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire rnad_pkg::rnad_sts_type sts,
   output rnad_pkg::rnad_cmd_type     cmd
);
   import rnad_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;
   localparam logic [1:0] ST_ERR  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = sts.radix_bad ? ST_ERR : ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (sts.last_bit && sts.quot_zero) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.slot_free) begin
               cmd.pop = 1'b1;
               if (sts.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ERR: begin
            if (sts.slot_free) begin
               cmd.emit_err = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rnad_dpath.sv
// Datapath: bit-serial restoring divider, digit stack and output register.
// Depends on rnad_pkg; driven by rnad_ctrl commands.
`default_nettype none

module rnad_dpath #(
   parameter int NUM_BITS = rnad_pkg::DEFAULT_NUM_BITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [rnad_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire rnad_pkg::rnad_cmd_type           cmd,
   output rnad_pkg::rnad_sts_type                sts,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [rnad_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tlast,
   output logic                                  rsp_tuser
);
   import rnad_pkg::*;

   localparam int VAL_W = (NUM_BITS < NUMBER_W) ? NUM_BITS : NUMBER_W;
   localparam int IDX_W = $clog2(VAL_W);
   localparam int SP_W  = $clog2(VAL_W + 1);
   localparam logic [IDX_W-1:0] LAST_CNT = IDX_W'(VAL_W - 1);
   localparam logic [SP_W-1:0]  ONE_SP   = SP_W'(1);

   logic [VAL_W-1:0]   value_ff, value_in;
   logic [RADIX_W-1:0] radix_ff;
   logic [CHAR_W-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic [SP_W-1:0]    sp_ff, sp_in;
   logic [CHAR_W-1:0]  digit_ff [VAL_W];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff;
   logic               rsp_last_ff;
   logic               rsp_bad_ff;

   logic [CHAR_W:0]    trial;
   logic [CHAR_W-1:0]  diff;
   logic               ge;
   logic [CHAR_W-1:0]  rem_step;
   logic [VAL_W-1:0]   value_step;
   logic [IDX_W-1:0]   top_idx;

   assign trial      = {rem_ff, value_ff[VAL_W-1]};
   assign diff       = trial[CHAR_W-1:0] - radix_ff;
   assign ge         = (trial >= {1'b0, radix_ff});
   assign rem_step   = ge ? diff : trial[CHAR_W-1:0];
   assign value_step = {value_ff[VAL_W-2:0], ge};
   assign top_idx    = IDX_W'(sp_ff - ONE_SP);

   assign sts.radix_bad  = (req_tdata[REQ_TDATA_W-1:NUMBER_W] < MIN_RADIX);
   assign sts.last_bit   = (cnt_ff == LAST_CNT);
   assign sts.quot_zero  = (value_step == '0);
   assign sts.last_digit = (sp_ff == ONE_SP);
   assign sts.slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      value_in = value_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      sp_in    = sp_ff;
      if (cmd.load) begin
         value_in = req_tdata[VAL_W-1:0];
         rem_in   = '0;
         cnt_in   = '0;
         sp_in    = '0;
      end else if (cmd.step) begin
         value_in = value_step;
         if (sts.last_bit) begin
            rem_in = '0;
            cnt_in = '0;
            sp_in  = sp_ff + ONE_SP;
         end else begin
            rem_in = rem_step;
            cnt_in = cnt_ff + 1'b1;
         end
      end else if (cmd.pop) begin
         sp_in = sp_ff - ONE_SP;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.pop || cmd.emit_err) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      rem_ff   <= rem_in;
      if (cmd.load) begin
         radix_ff <= req_tdata[REQ_TDATA_W-1:NUMBER_W];
      end
      if (cmd.step && sts.last_bit) begin
         digit_ff[sp_ff[IDX_W-1:0]] <= digit_char(rem_step);
      end
      if (cmd.pop) begin
         rsp_char_ff <= digit_ff[top_idx];
         rsp_last_ff <= sts.last_digit;
         rsp_bad_ff  <= 1'b0;
      end else if (cmd.emit_err) begin
         rsp_char_ff <= '0;
         rsp_last_ff <= 1'b1;
         rsp_bad_ff  <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_bad_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/radix_number_to_ascii_digits_unit.sv
// Top level of the radix number to ASCII digit converter.
// Depends on rnad_pkg, rnad_ctrl and rnad_dpath.
//
//  channel | dir | signals                         | contents
//  req     | in  | req_tvalid/tready/tdata[39:0]    | number, radix
//  rsp     | out | rsp_tvalid/tready/tdata/tlast/tuser | character, last, bad_radix
//
// One item with n digits is accepted, then divided digit by digit, W = min(NUM_BITS,32)
// quotient bits per digit at one quotient bit per cycle in the shared restoring divider,
// then its n digits are output; the worst case, radix 2, gives up to W digits.
// Reset is synchronous and clears only control state.
// A new word is taken once the previous one has gone into the output register;
// rsp_tready low holds the output register and stalls digit emission.
`default_nettype none

module radix_number_to_ascii_digits_unit #(
   parameter int NUM_BITS = rnad_pkg::DEFAULT_NUM_BITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [rnad_pkg::REQ_TDATA_W-1:0] req_tdata,  // number[31:0], radix[39:32]
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [rnad_pkg::RSP_TDATA_W-1:0]      rsp_tdata,  // character[7:0]
   output logic                                  rsp_tlast,
   output logic                                  rsp_tuser   // bad_radix[0]
);
   import rnad_pkg::*;

   rnad_cmd_type cmd;
   rnad_sts_type sts;

   rnad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rnad_dpath #(
      .NUM_BITS (NUM_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   a_err_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("error word must be last with zero character");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word accepted while converting");

   a_load_hs: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> req_tvalid && req_tready && !cmd.step && !cmd.pop)
      else $error("load command outside an input handshake");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop || cmd.emit_err) && rsp_tvalid |-> rsp_tready)
      else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
